// ----- rtl/hse_pkg.sv -----
// hse_pkg: shared types for the heap sort engine.
// Holds the sequencer state and phase types. No dependencies.
`default_nettype none

package hse_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    S_LOAD,
    S_FETCH,
    S_GRAB,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_SWAP_RD,
    S_SWAP_WR,
    S_EMIT_RD,
    S_EMIT_LD
  } hse_state_t;

  // Which pass the shared sift-down sequence belongs to
  typedef enum logic {
    PH_BUILD,
    PH_EXTRACT
  } hse_phase_t;

endpackage

`default_nettype wire

// ----- rtl/hse_in_if.sv -----
// hse_in_if: input channel of the heap sort engine (valid/ready + element).
// Standalone interface, no dependencies.
`default_nettype none

interface hse_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/hse_out_if.sv -----
// hse_out_if: result channel of the heap sort engine (valid/ready + sorted element).
// Standalone interface, no dependencies.
`default_nettype none

interface hse_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value_res;
  logic                         last_res;
  logic                         overflow;

  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink   (input valid, input value_res, input last_res, input overflow,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/heap_sort_engine_top.sv -----
// heap_sort_engine_top: collects a set of signed elements, heap-sorts it in a
// single-port-write / dual-read memory and returns it in ascending order.
// Depends on hse_pkg, hse_in_if, hse_out_if.
//
//   channel  | dir | fields                          | transfer when
//   ---------+-----+---------------------------------+---------------------------
//   item     | in  | value, last                     | item.valid & item.ready
//   result   | out | value_res, last_res, overflow   | result.valid & result.ready
//
// Loading takes one element per cycle. Sorting runs in the memory: each level
// of a sift-down issues the child reads, then compares and writes back; each
// root/end exchange reads both, then writes, and each build step first fetches
// the node. Each result is read, then loaded into the output register once free.
// Reset clears the sequencer, the element count and flags; the store needs no clearing.
// item.ready is high only while loading; the result register drains on its own.
`default_nettype none

module heap_sort_engine_top
  import hse_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire        clk,
  input  wire        rst,
  hse_in_if.sink     item,
  hse_out_if.source  result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;

  // Element store
  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_a, rd_b;
  logic                         we, re_a, re_b;
  logic [AW-1:0]                waddr, raddr_a, raddr_b;
  logic signed [DATA_WIDTH-1:0] wdata;

  // Control registers
  hse_state_t                   state, state_next;
  hse_phase_t                   phase, phase_next;
  logic [CW-1:0]                count, count_next;
  logic                         dropped, dropped_next;
  logic [CW-1:0]                n, n_next;
  logic [CW-1:0]                idx, idx_next;
  logic [AW-1:0]                node, node_next;
  logic [CW-1:0]                limit, limit_next;
  logic signed [DATA_WIDTH-1:0] cur, cur_next;

  // Output register
  logic                         out_valid, out_valid_next;
  logic signed [DATA_WIDTH-1:0] out_value, out_value_next;
  logic                         out_last, out_last_next;
  logic                         out_ovf, out_ovf_next;

  // Child addressing for the node being sifted
  logic [XW-1:0] child, child_r;
  logic          has_child, has_right, pick_right, do_move;
  logic signed [DATA_WIDTH-1:0] big;
  logic [XW-1:0] big_idx;
  logic          sift_done;
  logic [CW-1:0] n_load;
  logic          store_ok;

  assign child     = {1'b0, node, 1'b1};
  assign child_r   = child + XW'(1);
  assign has_child = child <= XW'(limit);
  assign has_right = child_r <= XW'(limit);
  assign pick_right = has_right && (rd_b > rd_a);
  assign big       = pick_right ? rd_b : rd_a;
  assign big_idx   = pick_right ? child_r : child;
  assign do_move   = big > cur;
  assign store_ok  = count < CW'(DEPTH);
  assign n_load    = store_ok ? count + CW'(1) : count;

  assign item.ready       = (state == S_LOAD);
  assign result.valid     = out_valid;
  assign result.value_res = out_value;
  assign result.last_res  = out_last;
  assign result.overflow  = out_ovf;

  // Next state, memory controls and register updates
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    count_next     = count;
    dropped_next   = dropped;
    n_next         = n;
    idx_next       = idx;
    node_next      = node;
    limit_next     = limit;
    cur_next       = cur;
    out_valid_next = out_valid && !result.ready;
    out_value_next = out_value;
    out_last_next  = out_last;
    out_ovf_next   = out_ovf;
    we             = 1'b0;
    waddr          = node;
    wdata          = cur;
    re_a           = 1'b0;
    re_b           = 1'b0;
    raddr_a        = child[AW-1:0];
    raddr_b        = child_r[AW-1:0];
    sift_done      = 1'b0;

    case (state)
      S_LOAD: begin
        if (item.valid) begin
          if (store_ok) begin
            we         = 1'b1;
            waddr      = count[AW-1:0];
            wdata      = item.value;
            count_next = count + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (item.last) begin
            n_next = n_load;
            if (n_load < CW'(2)) begin
              idx_next   = '0;
              state_next = S_EMIT_RD;
            end else begin
              phase_next = PH_BUILD;
              idx_next   = n_load >> 1;
              state_next = S_FETCH;
            end
          end
        end
      end

      // Build pass: read the node to sift
      S_FETCH: begin
        node_next  = AW'(idx - CW'(1));
        limit_next = n - CW'(1);
        re_a       = 1'b1;
        raddr_a    = AW'(idx - CW'(1));
        state_next = S_GRAB;
      end

      S_GRAB: begin
        cur_next   = rd_a;
        state_next = S_SIFT_RD;
      end

      // Issue reads of both children, or settle the value if none
      S_SIFT_RD: begin
        if (has_child) begin
          re_a       = 1'b1;
          re_b       = 1'b1;
          state_next = S_SIFT_CMP;
        end else begin
          we        = 1'b1;
          sift_done = 1'b1;
        end
      end

      // Move the larger child up, or drop the held value here
      S_SIFT_CMP: begin
        we = 1'b1;
        if (do_move) begin
          wdata      = big;
          node_next  = big_idx[AW-1:0];
          state_next = S_SIFT_RD;
        end else begin
          sift_done = 1'b1;
        end
      end

      // Extract pass: exchange root and end of region
      S_SWAP_RD: begin
        re_a       = 1'b1;
        re_b       = 1'b1;
        raddr_a    = '0;
        raddr_b    = idx[AW-1:0];
        state_next = S_SWAP_WR;
      end

      S_SWAP_WR: begin
        we         = 1'b1;
        waddr      = idx[AW-1:0];
        wdata      = rd_a;
        cur_next   = rd_b;
        node_next  = '0;
        limit_next = idx - CW'(1);
        state_next = S_SIFT_RD;
      end

      S_EMIT_RD: begin
        re_a       = 1'b1;
        raddr_a    = idx[AW-1:0];
        state_next = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        if (!out_valid || result.ready) begin
          out_valid_next = 1'b1;
          out_value_next = rd_a;
          out_last_next  = (idx + CW'(1) == n);
          out_ovf_next   = dropped;
          if (idx + CW'(1) == n) begin
            count_next   = '0;
            dropped_next = 1'b0;
            state_next   = S_LOAD;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase

    // Sequencing after a finished sift-down
    if (sift_done) begin
      if (phase == PH_BUILD) begin
        if (idx > CW'(1)) begin
          idx_next   = idx - CW'(1);
          state_next = S_FETCH;
        end else begin
          phase_next = PH_EXTRACT;
          idx_next   = n - CW'(1);
          state_next = S_SWAP_RD;
        end
      end else begin
        if (idx > CW'(1)) begin
          idx_next   = idx - CW'(1);
          state_next = S_SWAP_RD;
        end else begin
          idx_next   = '0;
          state_next = S_EMIT_RD;
        end
      end
    end
  end

  // Store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a <= mem[raddr_a];
    end
    if (re_b) begin
      rd_b <= mem[raddr_b];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      phase     <= PH_BUILD;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      count     <= count_next;
      dropped   <= dropped_next;
      out_valid <= out_valid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n         <= n_next;
    idx       <= idx_next;
    node      <= node_next;
    limit     <= limit_next;
    cur       <= cur_next;
    out_value <= out_value_next;
    out_last  <= out_last_next;
    out_ovf   <= out_ovf_next;
  end

endmodule

`default_nettype wire
